>>> rtl/apt_pkg.sv
// Shared widths and constants for the affine point transform.
`default_nettype none
package apt_pkg;

	localparam int COORD_W   = 32;  // Q16.16 point coordinate
	localparam int COEF_W    = 32;  // Q8.24 matrix coefficient
	localparam int CFG_W     = 64;  // two coefficients per register
	localparam int PROD_W    = COORD_W + COEF_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;
	localparam int FRAC_SHIFT  = 24;  // Q24.40 down to Q16.16
	localparam int TRANS_SHIFT = 16;  // translation times 1.0 in Q16.16

	localparam int REG_NUM   = 6;
	localparam int CFG_IDX_W = 3;

	// Register indexes, in the order of the register map.
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;

	// Identity matrix with zero translation.
	localparam logic [CFG_W-1:0] CFG_RESET [REG_NUM] = '{
		64'h0000_0000_0100_0000, 64'h0,
		64'h0100_0000_0000_0000, 64'h0,
		64'h0,                   64'h0000_0000_0100_0000
	};

	localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage
`default_nettype wire

>>> rtl/apt_row.sv
// One matrix row: three products plus translation, shifted and saturated in four stages.
`default_nettype none
module apt_row (
	input  wire logic                               clk,
	input  wire logic signed [apt_pkg::COORD_W-1:0] px,
	input  wire logic signed [apt_pkg::COORD_W-1:0] py,
	input  wire logic signed [apt_pkg::COORD_W-1:0] pz,
	input  wire logic        [apt_pkg::CFG_W-1:0]   cols01,
	input  wire logic        [apt_pkg::CFG_W-1:0]   cols23,
	output logic      signed [apt_pkg::COORD_W-1:0] res,
	output logic                                    ovf
);
	import apt_pkg::*;

	logic signed [COEF_W-1:0]  c0, c1, c2, c3;
	logic signed [PROD_W-1:0]  prod0_s1, prod1_s1, prod2_s1, trans_s1;
	logic signed [PAIR_W-1:0]  sum01_s2, sum23_s2;
	logic signed [SUM_W-1:0]   sum_s3;
	logic [SUM_W-1:FRAC_SHIFT+COORD_W-1] hi_bits;
	logic                      fits;
	logic signed [COORD_W-1:0] res_s4;
	logic                      ovf_s4;

	assign c0 = cols01[COEF_W-1:0];
	assign c1 = cols01[CFG_W-1:COEF_W];
	assign c2 = cols23[COEF_W-1:0];
	assign c3 = cols23[CFG_W-1:COEF_W];

	// Payload only; the valid bits travel in the top level.
	always_ff @(posedge clk) begin
		prod0_s1 <= c0 * px;
		prod1_s1 <= c1 * py;
		prod2_s1 <= c2 * pz;
		trans_s1 <= {{(PROD_W-COEF_W-TRANS_SHIFT){c3[COEF_W-1]}}, c3, {TRANS_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk) begin
		sum01_s2 <= {prod0_s1[PROD_W-1], prod0_s1} + {prod1_s1[PROD_W-1], prod1_s1};
		sum23_s2 <= {prod2_s1[PROD_W-1], prod2_s1} + {trans_s1[PROD_W-1], trans_s1};
	end

	always_ff @(posedge clk) begin
		sum_s3 <= {sum01_s2[PAIR_W-1], sum01_s2} + {sum23_s2[PAIR_W-1], sum23_s2};
	end

	// The shifted value fits in 32 bits when every bit above its sign bit matches it.
	assign hi_bits = sum_s3[SUM_W-1:FRAC_SHIFT+COORD_W-1];
	assign fits    = (&hi_bits) | ~(|hi_bits);

	always_ff @(posedge clk) begin
		if (fits) begin
			res_s4 <= sum_s3[FRAC_SHIFT+COORD_W-1:FRAC_SHIFT];
		end else if (sum_s3[SUM_W-1]) begin
			res_s4 <= SAT_MIN;
		end else begin
			res_s4 <= SAT_MAX;
		end
		ovf_s4 <= ~fits;
	end

	assign res = res_s4;
	assign ovf = ovf_s4;

endmodule
`default_nettype wire

>>> rtl/affine_point_transform.sv
// A point taken with start gives its result with done after the valid registers vld_s1, vld_s2, vld_s3 and done_s4.
// Throughput: one point per cycle; busy stays low and start may be held high.
// Each row has three 32x32 multipliers feeding a two-level adder tree, then saturation.
// Reset clears the valid bits in flight and loads the identity matrix.
// Results are shown for one cycle only; the receiver cannot stall them.
`default_nettype none
module affine_point_transform (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [apt_pkg::COORD_W-1:0]   px,
	input  wire logic signed [apt_pkg::COORD_W-1:0]   py,
	input  wire logic signed [apt_pkg::COORD_W-1:0]   pz,
	input  wire logic                                 cfg_we,
	input  wire logic        [apt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [apt_pkg::CFG_W-1:0]     cfg_data,
	output logic                                      done,
	output logic      signed [apt_pkg::COORD_W-1:0]   tx,
	output logic      signed [apt_pkg::COORD_W-1:0]   ty,
	output logic      signed [apt_pkg::COORD_W-1:0]   tz,
	output logic                                      overflow
);
	import apt_pkg::*;

	logic [CFG_W-1:0] cfg_q [REG_NUM];
	logic             vld_s1, vld_s2, vld_s3, done_s4;
	logic             ovf_x, ovf_y, ovf_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_NUM; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(REG_NUM))) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			done_s4 <= 1'b0;
		end else begin
			vld_s1  <= start;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			done_s4 <= vld_s3;
		end
	end

	apt_row u_row_x (
		.clk    (clk),
		.px     (px),
		.py     (py),
		.pz     (pz),
		.cols01 (cfg_q[REG_ROW0_COLS01]),
		.cols23 (cfg_q[REG_ROW0_COLS23]),
		.res    (tx),
		.ovf    (ovf_x)
	);

	apt_row u_row_y (
		.clk    (clk),
		.px     (px),
		.py     (py),
		.pz     (pz),
		.cols01 (cfg_q[REG_ROW1_COLS01]),
		.cols23 (cfg_q[REG_ROW1_COLS23]),
		.res    (ty),
		.ovf    (ovf_y)
	);

	apt_row u_row_z (
		.clk    (clk),
		.px     (px),
		.py     (py),
		.pz     (pz),
		.cols01 (cfg_q[REG_ROW2_COLS01]),
		.cols23 (cfg_q[REG_ROW2_COLS23]),
		.res    (tz),
		.ovf    (ovf_z)
	);

	assign busy     = 1'b0;
	assign done     = done_s4;
	assign overflow = ovf_x | ovf_y | ovf_z;

	// Every beat taken comes out on done after passing vld_s1, vld_s2, vld_s3 and done_s4.
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done)
		else $error("accepted point did not complete after four cycles");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result strobe without a matching point");

	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (tx == SAT_MAX || tx == SAT_MIN ||
			ty == SAT_MAX || ty == SAT_MIN || tz == SAT_MAX || tz == SAT_MIN))
		else $error("overflow flagged but no component is saturated");

endmodule
`default_nettype wire

>>> verif/apt_result_checker.sv
// Result checker for the affine point transform: predicts each transformed point and compares.
module apt_result_checker
	import apt_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic signed [COORD_W-1:0]   px,
	input  wire logic signed [COORD_W-1:0]   py,
	input  wire logic signed [COORD_W-1:0]   pz,
	input  wire logic                        cfg_we,
	input  wire logic        [CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [CFG_W-1:0]     cfg_data,
	input  wire logic                        done,
	input  wire logic signed [COORD_W-1:0]   tx,
	input  wire logic signed [COORD_W-1:0]   ty,
	input  wire logic signed [COORD_W-1:0]   tz,
	input  wire logic                        overflow,
	output int                               fail_count,
	output int                               pending
);

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic signed [COORD_W-1:0] tx;
		logic signed [COORD_W-1:0] ty;
		logic signed [COORD_W-1:0] tz;
		logic                      ovf;
	} point_result_t;

	logic [CFG_W-1:0] matrix_regs [REG_NUM];
	point_result_t    expected_points [$];
	point_result_t    got, want;
	int               result_no;

	initial begin
		fail_count = 0;
		pending    = 0;
		result_no  = 0;
	end

	// One row of the matrix applied to (x, y, z, 1); flags saturation through sat.
	function automatic logic signed [COORD_W-1:0] transform_row(
		input logic [CFG_W-1:0] cols01,
		input logic [CFG_W-1:0] cols23,
		input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y,
		input logic signed [COORD_W-1:0] z,
		inout logic sat
	);
		logic signed [COEF_W-1:0] c0, c1, c2, c3;
		logic signed [SUM_W-1:0]  acc, scaled;
		c0 = cols01[COEF_W-1:0];
		c1 = cols01[CFG_W-1:COEF_W];
		c2 = cols23[COEF_W-1:0];
		c3 = cols23[CFG_W-1:COEF_W];
		// The translation is multiplied by 1.0 in Q16.16, i.e. shifted up by 16.
		acc    = c0 * x + c1 * y + c2 * z + (c3 <<< TRANS_SHIFT);
		scaled = acc >>> FRAC_SHIFT;
		if (~|scaled[SUM_W-1:COORD_W-1] || &scaled[SUM_W-1:COORD_W-1])
			return scaled[COORD_W-1:0];
		sat = 1'b1;
		return scaled[SUM_W-1] ? SAT_MIN : SAT_MAX;
	endfunction

	function automatic point_result_t transform_point(
		input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y,
		input logic signed [COORD_W-1:0] z
	);
		point_result_t r;
		logic          sat;
		sat  = 1'b0;
		r.tx = transform_row(matrix_regs[REG_ROW0_COLS01], matrix_regs[REG_ROW0_COLS23],
			x, y, z, sat);
		r.ty = transform_row(matrix_regs[REG_ROW1_COLS01], matrix_regs[REG_ROW1_COLS23],
			x, y, z, sat);
		r.tz = transform_row(matrix_regs[REG_ROW2_COLS01], matrix_regs[REG_ROW2_COLS23],
			x, y, z, sat);
		r.ovf = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// Identity matrix, no translation.
			matrix_regs[REG_ROW0_COLS01] = 64'h0000_0000_0100_0000;
			matrix_regs[REG_ROW0_COLS23] = 64'h0;
			matrix_regs[REG_ROW1_COLS01] = 64'h0100_0000_0000_0000;
			matrix_regs[REG_ROW1_COLS23] = 64'h0;
			matrix_regs[REG_ROW2_COLS01] = 64'h0;
			matrix_regs[REG_ROW2_COLS23] = 64'h0000_0000_0100_0000;
			expected_points.delete();
			pending = 0;
		end else begin
			if (done) begin
				result_no++;
				got = {tx, ty, tz, overflow};
				if (expected_points.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("result %0d arrived with no point outstanding: tx=%h ty=%h tz=%h ovf=%b",
							result_no, got.tx, got.ty, got.tz, got.ovf);
				end else begin
					want = expected_points.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("result %0d differs: expected tx=%h ty=%h tz=%h ovf=%b, got tx=%h ty=%h tz=%h ovf=%b",
								result_no, want.tx, want.ty, want.tz, want.ovf,
								got.tx, got.ty, got.tz, got.ovf);
					end
				end
			end
			if (start && !busy)
				expected_points.push_back(transform_point(px, py, pz));
			// Writes to indexes beyond the register map are dropped.
			if (cfg_we && cfg_index < REG_NUM)
				matrix_regs[cfg_index] = cfg_data;
			pending = expected_points.size();
		end
	end

endmodule

>>> verif/tb_affine_point_transform.sv
// Testbench top for the affine point transform: point and matrix stimulus, watchdog and verdict.
module tb_affine_point_transform;
	import apt_pkg::*;

	localparam int LATENCY        = 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_POINTS   = 142;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	localparam logic [COEF_W-1:0] COEF_ONE      = 32'h0100_0000;
	localparam logic [COEF_W-1:0] COEF_HALF     = 32'h0080_0000;
	localparam logic [COEF_W-1:0] COEF_NEG_HALF = 32'hFF80_0000;
	localparam logic [COEF_W-1:0] COEF_NEG_ONE  = 32'hFF00_0000;
	localparam logic [COEF_W-1:0] COEF_MAX      = 32'h7FFF_FFFF;
	localparam logic [COEF_W-1:0] COEF_MIN      = 32'h8000_0000;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic signed [COORD_W-1:0]   px = '0;
	logic signed [COORD_W-1:0]   py = '0;
	logic signed [COORD_W-1:0]   pz = '0;
	logic                        cfg_we = 1'b0;
	logic        [CFG_IDX_W-1:0] cfg_index = '0;
	logic        [CFG_W-1:0]     cfg_data = '0;
	wire logic                   busy;
	wire logic                   done;
	wire logic signed [COORD_W-1:0] tx;
	wire logic signed [COORD_W-1:0] ty;
	wire logic signed [COORD_W-1:0] tz;
	wire logic                   overflow;
	int                          fail_count;
	int                          pending;
	int                          quiet_cycles = 0;
	bit                          gaps_on = 1'b1;
	logic        [CFG_W-1:0]     next_regs [REG_NUM];

	always #5 clk = ~clk;

	affine_point_transform u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.px        (px),
		.py        (py),
		.pz        (pz),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.tx        (tx),
		.ty        (ty),
		.tz        (tz),
		.overflow  (overflow)
	);

	apt_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.px         (px),
		.py         (py),
		.pz         (pz),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.tx         (tx),
		.ty         (ty),
		.tz         (tz),
		.overflow   (overflow),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Ends a hung run: too long without a point or a result changing hands.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("affine_point_transform: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Tame draws stay well inside range, so most of their results are not saturated.
	function automatic logic [COORD_W-1:0] rand_coord(input bit tame);
		logic [31:0] r;
		int          mode;
		r    = $urandom;
		mode = tame ? $urandom_range(2, 4) : $urandom_range(0, 5);
		case (mode)
			0, 1:    return r;
			2:       return {{12{r[19]}}, r[19:0]};
			3:       return {{16{r[15]}}, r[15:0]};
			4:       return {{8{r[23]}}, r[23:0]};
			default: begin
				case (r[1:0])
					2'd0:    return SAT_MAX;
					2'd1:    return SAT_MIN;
					2'd2:    return 32'h0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef(input bit tame);
		logic [31:0] r;
		int          mode;
		r    = $urandom;
		mode = tame ? $urandom_range(1, 3) : $urandom_range(0, 4);
		case (mode)
			0:       return r;
			1:       return {{7{r[24]}}, r[24:0]};
			2:       return {{4{r[27]}}, r[27:0]};
			3:       return 32'h0;
			default: begin
				case (r[1:0])
					2'd0:    return COEF_MAX;
					2'd1:    return COEF_MIN;
					2'd2:    return COEF_ONE;
					default: return COEF_NEG_ONE;
				endcase
			end
		endcase
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
	endtask

	// Loads next_regs, then pokes the two unmapped indexes, which must change nothing.
	task automatic program_matrix();
		for (int r = 0; r < REG_NUM; r++)
			cfg_write(CFG_IDX_W'(r), next_regs[r]);
		cfg_write(REG_UNMAPPED_LO, {$urandom, $urandom});
		cfg_write(REG_UNMAPPED_HI, {$urandom, $urandom});
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Holds off the sender until every outstanding point has come back.
	task automatic quiesce();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z);
		@(negedge clk);
		start = 1'b1;
		px    = x;
		py    = y;
		pz    = z;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
	endtask

	task automatic maybe_gap();
		int n;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 8);
			repeat (n) begin
				@(negedge clk);
				start = 1'b0;
				px    = $urandom;
				py    = $urandom;
				pz    = $urandom;
			end
		end
	endtask

	initial begin
		bit tame;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Matrix straight out of reset: identity, results equal the point.
		send_point(32'h0, 32'h0, 32'h0);
		send_point(SAT_MAX, SAT_MIN, 32'h1);
		send_point(SAT_MIN, SAT_MAX, 32'hFFFF_FFFF);
		send_point(32'h0001_8000, 32'hFFFE_8000, 32'h1234_5678);
		quiesce();

		// Halving rows show floor rounding on odd inputs; row 2 saturates both ways.
		next_regs[REG_ROW0_COLS01] = {32'h0, COEF_HALF};
		next_regs[REG_ROW0_COLS23] = {COEF_ONE, 32'h0};
		next_regs[REG_ROW1_COLS01] = {COEF_NEG_HALF, 32'h0};
		next_regs[REG_ROW1_COLS23] = 64'h0;
		next_regs[REG_ROW2_COLS01] = {COEF_MAX, COEF_MAX};
		next_regs[REG_ROW2_COLS23] = {COEF_MIN, COEF_MIN};
		program_matrix();
		send_point(32'h1, 32'h1, 32'h0);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		send_point(32'h3, 32'hFFFF_FFFD, 32'h0);
		send_point(32'h0, 32'h0, 32'h0);
		send_point(SAT_MAX, SAT_MIN, 32'h0);
		send_point(SAT_MIN, SAT_MAX, SAT_MIN);
		send_point(32'h0, 32'h0, SAT_MAX);
		quiesce();

		// Every coefficient at its most negative value.
		for (int r = 0; r < REG_NUM; r++)
			next_regs[r] = {COEF_MIN, COEF_MIN};
		program_matrix();
		send_point(SAT_MIN, SAT_MIN, SAT_MIN);
		send_point(SAT_MAX, SAT_MAX, SAT_MAX);
		send_point(32'h0, 32'h0, 32'h0);
		quiesce();

		// Every coefficient at its most positive value.
		for (int r = 0; r < REG_NUM; r++)
			next_regs[r] = {COEF_MAX, COEF_MAX};
		program_matrix();
		send_point(SAT_MIN, SAT_MIN, SAT_MIN);
		send_point(SAT_MAX, SAT_MAX, SAT_MAX);
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h1, 32'h1, 32'h1);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			quiesce();
			tame    = ph[0];
			gaps_on = (ph != RANDOM_PHASES - 1);
			for (int r = 0; r < REG_NUM; r++)
				next_regs[r] = {rand_coef(tame), rand_coef(tame)};
			program_matrix();
			repeat (PHASE_POINTS) begin
				maybe_gap();
				// Wild phases still mix in tame points so some results stay in range.
				send_point(rand_coord(tame || $urandom_range(0, 2) == 0),
					rand_coord(tame || $urandom_range(0, 2) == 0),
					rand_coord(tame || $urandom_range(0, 2) == 0));
			end
		end

		quiesce();
		if (fail_count == 0 && pending == 0)
			$display("affine_point_transform: match");
		else
			$display("affine_point_transform: mismatch");
		$finish;
	end

endmodule
